### rtl/assert_macros.svh
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// checked while reset is released
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/uwe_pkg.sv
// shared types, constants and helpers of the unique word extractor
package uwe_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int WORD_MAX    = 49;
  localparam int STORE_DEPTH = TABLE_DEPTH * WORD_MAX;

  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LEN_W  = $clog2(WORD_MAX + 1);
  localparam int WBI_W  = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // stride between table entries in the word store
  localparam logic [ADDR_W:0] WM_STEP = (ADDR_W+1)'(WORD_MAX);

  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_HYPH  = 8'h2d;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef enum logic [1:0] {
    CMD_ECHO,
    CMD_KEEP,
    CMD_FLUSH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       eot;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ECHO,
    ST_FLUSH,
    ST_RDL,
    ST_CMPL,
    ST_RDB,
    ST_CMPB,
    ST_NF,
    ST_FULL,
    ST_CRD,
    ST_CWR,
    ST_EQ,
    ST_LF,
    ST_FIN
  } back_state_t;

  function automatic logic is_sep(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  endfunction

endpackage

### rtl/uwe_front.sv
// front end: tracks the title line and turns bytes into commands
module uwe_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tlast,
  input  uwe_pkg::queue_sts_t q_sts,
  output logic             q_push,
  output uwe_pkg::cmd_t    q_cmd
);

  logic title_r, title_nxt;
  logic fire;
  logic upper, keep;

  assign in_tready = !q_sts.full;
  assign fire      = in_tvalid && in_tready;

  assign upper = (in_tdata >= uwe_pkg::CH_UA) && (in_tdata <= uwe_pkg::CH_UZ);
  assign keep  = upper || ((in_tdata >= uwe_pkg::CH_LA) && (in_tdata <= uwe_pkg::CH_LZ)) ||
                 (in_tdata == uwe_pkg::CH_APOS) || (in_tdata == uwe_pkg::CH_HYPH);

  always_comb begin
    q_push      = 1'b0;
    q_cmd.kind  = uwe_pkg::CMD_FLUSH;
    q_cmd.data  = upper ? in_tdata + uwe_pkg::CASE_GAP : in_tdata;
    q_cmd.eot   = in_tlast;
    title_nxt   = title_r;
    if (fire) begin
      if (title_r) begin
        q_push     = 1'b1;
        q_cmd.kind = uwe_pkg::CMD_ECHO;
        q_cmd.data = in_tdata;
        if (in_tdata == uwe_pkg::CH_LF) title_nxt = 1'b0;
      end else if (uwe_pkg::is_sep(in_tdata)) begin
        q_push = 1'b1;
      end else if (keep) begin
        q_push     = 1'b1;
        q_cmd.kind = uwe_pkg::CMD_KEEP;
      end else begin
        // dropped byte only matters when it ends the text
        q_push = in_tlast;
      end
      if (in_tlast) title_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) title_r <= 1'b1;
    else        title_r <= title_nxt;
  end

endmodule

### rtl/uwe_queue.sv
// small command queue between front end and back end
module uwe_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  uwe_pkg::cmd_t       push_cmd,
  input  logic                pop,
  output uwe_pkg::cmd_t       head,
  output uwe_pkg::queue_sts_t sts
);

  uwe_pkg::cmd_t mem_r [uwe_pkg::QUEUE_DEPTH];
  logic [uwe_pkg::QP_W-1:0] wp_r, rp_r;
  logic [uwe_pkg::QP_W:0]   cnt_r;

  assign head      = mem_r[rp_r];
  assign sts.full  = (cnt_r == (uwe_pkg::QP_W+1)'(uwe_pkg::QUEUE_DEPTH));
  assign sts.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (!push && pop) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

### rtl/uwe_back.sv
// back end: word buffer, table search, append and result register
module uwe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  uwe_pkg::cmd_t       head,
  input  uwe_pkg::queue_sts_t q_sts,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tuser,
  output logic                out_tlast
);

  uwe_pkg::back_state_t state_r, state_nxt;
  uwe_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [uwe_pkg::LEN_W-1:0]  len_r, len_nxt, j_r, j_nxt;
  logic [uwe_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic [uwe_pkg::ADDR_W:0]   base_r, base_nxt, endb_r, endb_nxt;

  logic [7:0] wbuf [uwe_pkg::WORD_MAX];
  logic [7:0] store [uwe_pkg::STORE_DEPTH];
  logic [uwe_pkg::LEN_W-1:0] lens [uwe_pkg::TABLE_DEPTH];
  logic [7:0] wbuf_q, store_q;
  logic [uwe_pkg::LEN_W-1:0] lens_q;

  logic [uwe_pkg::ADDR_W:0]   rd_sum, wr_sum;
  logic [uwe_pkg::ADDR_W-1:0] st_ra, st_wa;

  logic slot_free;
  logic emit, emit_status, emit_last;
  logic [7:0] emit_byte;
  logic wbuf_we, st_we, len_we;
  logic last_entry;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_status_r, out_last_r;

  assign slot_free  = !out_valid_r || out_tready;
  assign rd_sum     = base_r + (uwe_pkg::ADDR_W+1)'(j_r);
  assign wr_sum     = endb_r + (uwe_pkg::ADDR_W+1)'(j_r);
  assign st_ra      = rd_sum[uwe_pkg::ADDR_W-1:0];
  assign st_wa      = wr_sum[uwe_pkg::ADDR_W-1:0];
  assign last_entry = (idx_r + 1'b1 == cnt_r);

  // next state and register updates
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    base_nxt  = base_r;
    endb_nxt  = endb_r;
    case (state_r)
      uwe_pkg::ST_IDLE: begin
        if (!q_sts.empty) begin
          cmd_nxt = head;
          case (head.kind)
            uwe_pkg::CMD_ECHO: state_nxt = uwe_pkg::ST_ECHO;
            uwe_pkg::CMD_KEEP: begin
              if (len_r < uwe_pkg::LEN_W'(uwe_pkg::WORD_MAX)) len_nxt = len_r + 1'b1;
              if (head.eot) state_nxt = uwe_pkg::ST_FLUSH;
            end
            default: state_nxt = uwe_pkg::ST_FLUSH;
          endcase
        end
      end
      uwe_pkg::ST_ECHO: if (slot_free) state_nxt = uwe_pkg::ST_FIN;
      uwe_pkg::ST_FLUSH: begin
        idx_nxt  = '0;
        base_nxt = '0;
        if (len_r == '0)      state_nxt = uwe_pkg::ST_FIN;
        else if (cnt_r == '0) state_nxt = uwe_pkg::ST_NF;
        else                  state_nxt = uwe_pkg::ST_RDL;
      end
      uwe_pkg::ST_RDL: state_nxt = uwe_pkg::ST_CMPL;
      uwe_pkg::ST_CMPL: begin
        j_nxt = '0;
        if (lens_q == len_r) begin
          state_nxt = uwe_pkg::ST_RDB;
        end else if (last_entry) begin
          state_nxt = uwe_pkg::ST_NF;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          base_nxt  = base_r + uwe_pkg::WM_STEP;
          state_nxt = uwe_pkg::ST_RDL;
        end
      end
      uwe_pkg::ST_RDB: state_nxt = uwe_pkg::ST_CMPB;
      uwe_pkg::ST_CMPB: begin
        if (store_q == wbuf_q) begin
          if (j_r + 1'b1 == len_r) begin
            state_nxt = uwe_pkg::ST_FIN;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = uwe_pkg::ST_RDB;
          end
        end else if (last_entry) begin
          state_nxt = uwe_pkg::ST_NF;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          base_nxt  = base_r + uwe_pkg::WM_STEP;
          state_nxt = uwe_pkg::ST_RDL;
        end
      end
      uwe_pkg::ST_NF: begin
        j_nxt = '0;
        if (cnt_r == uwe_pkg::CNT_W'(uwe_pkg::TABLE_DEPTH)) state_nxt = uwe_pkg::ST_FULL;
        else                                                state_nxt = uwe_pkg::ST_CRD;
      end
      uwe_pkg::ST_FULL: if (slot_free) state_nxt = uwe_pkg::ST_FIN;
      uwe_pkg::ST_CRD:  state_nxt = uwe_pkg::ST_CWR;
      uwe_pkg::ST_CWR: begin
        if (slot_free) begin
          j_nxt = j_r + 1'b1;
          if (j_r + 1'b1 == len_r) state_nxt = uwe_pkg::ST_EQ;
          else                     state_nxt = uwe_pkg::ST_CRD;
        end
      end
      uwe_pkg::ST_EQ: if (slot_free) state_nxt = uwe_pkg::ST_LF;
      uwe_pkg::ST_LF: begin
        if (slot_free) begin
          cnt_nxt   = cnt_r + 1'b1;
          endb_nxt  = endb_r + uwe_pkg::WM_STEP;
          state_nxt = uwe_pkg::ST_FIN;
        end
      end
      uwe_pkg::ST_FIN: begin
        len_nxt = '0;
        if (cmd_r.eot) begin
          cnt_nxt  = '0;
          endb_nxt = '0;
        end
        state_nxt = uwe_pkg::ST_IDLE;
      end
      default: state_nxt = uwe_pkg::ST_IDLE;
    endcase
  end

  // outputs of each state
  always_comb begin
    q_pop       = 1'b0;
    emit        = 1'b0;
    emit_byte   = '0;
    emit_status = 1'b0;
    emit_last   = 1'b0;
    wbuf_we     = 1'b0;
    st_we       = 1'b0;
    len_we      = 1'b0;
    case (state_r)
      uwe_pkg::ST_IDLE: begin
        q_pop   = !q_sts.empty;
        wbuf_we = !q_sts.empty && (head.kind == uwe_pkg::CMD_KEEP) &&
                  (len_r < uwe_pkg::LEN_W'(uwe_pkg::WORD_MAX));
      end
      uwe_pkg::ST_ECHO: begin
        emit      = slot_free;
        emit_byte = cmd_r.data;
        emit_last = 1'b1;
      end
      uwe_pkg::ST_NF: len_we = (cnt_r != uwe_pkg::CNT_W'(uwe_pkg::TABLE_DEPTH));
      uwe_pkg::ST_FULL: begin
        emit        = slot_free;
        emit_status = 1'b1;
        emit_last   = 1'b1;
      end
      uwe_pkg::ST_CWR: begin
        emit      = slot_free;
        emit_byte = wbuf_q;
        st_we     = slot_free;
      end
      uwe_pkg::ST_EQ: begin
        emit      = slot_free;
        emit_byte = uwe_pkg::CH_EQ;
      end
      uwe_pkg::ST_LF: begin
        emit      = slot_free;
        emit_byte = uwe_pkg::CH_LF;
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  // word buffer, word store and length table
  always_ff @(posedge clk) begin
    if (wbuf_we) wbuf[len_r[uwe_pkg::WBI_W-1:0]] <= head.data;
    wbuf_q <= wbuf[j_r[uwe_pkg::WBI_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (st_we) store[st_wa] <= wbuf_q;
    store_q <= store[st_ra];
  end

  always_ff @(posedge clk) begin
    if (len_we) lens[cnt_r[uwe_pkg::IDX_W-1:0]] <= len_r;
    lens_q <= lens[idx_r[uwe_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= uwe_pkg::ST_IDLE;
      len_r       <= '0;
      cnt_r       <= '0;
      endb_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      endb_r  <= endb_nxt;
      if (emit)            out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    j_r    <= j_nxt;
    idx_r  <= idx_nxt;
    base_r <= base_nxt;
    if (emit) begin
      out_byte_r   <= emit_byte;
      out_status_r <= emit_status;
      out_last_r   <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

### rtl/unique_word_extractor.sv
// top level of the unique word extractor
//  channel | dir | tdata          | tuser      | tlast
//  in_     | in  | text_byte[7:0] | -          | end_of_text
//  out_    | out | out_byte[7:0]  | out_status | out_last
// a title byte passes the echo state; a word byte goes into the word buffer
// a word end scans the table one entry at a time, length first, then
// byte by byte; a new word is appended and emitted with '=' and LF
// rst_n is synchronous; table and title state clear at once, no clearing pass
// the command queue holds 4 items so input is taken while the back end stalls
`include "assert_macros.svh"
module unique_word_extractor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // text_byte[7:0]
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte[7:0]
  output logic [0:0] out_tuser,  // out_status[0]
  output logic       out_tlast
);

  uwe_pkg::queue_sts_t q_sts;
  uwe_pkg::cmd_t       push_cmd, head;
  logic                q_push, q_pop;
  logic                status_bit;

  uwe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_sts     (q_sts),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  uwe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .sts      (q_sts)
  );

  uwe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_sts      (q_sts),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (status_bit),
    .out_tlast  (out_tlast)
  );

  assign out_tuser[0] = status_bit;

  `ASSERT_RST(a_status_is_last, clk, rst_n, out_tvalid && out_tuser[0] |-> out_tlast && out_tdata == 8'h00)
  `ASSERT_RST(a_no_push_when_full, clk, rst_n, q_push |-> !q_sts.full)
  `ASSERT_RST(a_no_pop_when_empty, clk, rst_n, q_pop |-> !q_sts.empty)
  `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid && q_sts.empty)

endmodule

### tb/tb_top.sv
// testbench of the unique word extractor: directed and random text streams
`timescale 1ns / 1ps
module tb_top;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [0:0] out_tuser;
  logic       out_tlast;

  unique_word_extractor dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  typedef struct packed {
    logic [7:0] ch;
    logic       status;
    logic       last;
  } out_beat_t;

  // predictor state
  logic        title_pending;
  logic [7:0]  cur_word[uwe_pkg::WORD_MAX];
  int          cur_len;
  int          word_count;
  logic [7:0]  known_words[uwe_pkg::TABLE_DEPTH][uwe_pkg::WORD_MAX];
  int          known_lens[uwe_pkg::TABLE_DEPTH];

  out_beat_t   pending_beats[$];
  int          errors;
  int          sent_bytes;
  int          emitted_beats;
  int          dropped_words;
  bit          quiet;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit word_known();
    for (int i = 0; i < word_count; i++) begin
      if (known_lens[i] == cur_len) begin
        bit same;
        same = 1'b1;
        for (int k = 0; k < cur_len; k++)
          if (known_words[i][k] != cur_word[k]) same = 1'b0;
        if (same) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void push_beat(logic [7:0] c, logic st);
    out_beat_t b;
    b.ch = c;
    b.status = st;
    b.last = 1'b0;
    pending_beats.push_back(b);
  endfunction

  function automatic void flush_word();
    if (cur_len == 0) return;
    if (!word_known()) begin
      if (word_count >= uwe_pkg::TABLE_DEPTH) begin
        push_beat(8'h00, 1'b1);
        dropped_words++;
      end else begin
        for (int k = 0; k < cur_len; k++) known_words[word_count][k] = cur_word[k];
        known_lens[word_count] = cur_len;
        word_count++;
        for (int k = 0; k < cur_len; k++) push_beat(cur_word[k], 1'b0);
        push_beat(uwe_pkg::CH_EQ, 1'b0);
        push_beat(uwe_pkg::CH_LF, 1'b0);
      end
    end
    cur_len = 0;
  endfunction

  function automatic void predict_byte(logic [7:0] c, logic eot);
    int before_n;
    logic [7:0] k;
    before_n = pending_beats.size();
    if (title_pending) begin
      push_beat(c, 1'b0);
      if (c == uwe_pkg::CH_LF) title_pending = 1'b0;
    end else if (c == uwe_pkg::CH_SPACE || c == uwe_pkg::CH_TAB ||
                 c == uwe_pkg::CH_CR || c == uwe_pkg::CH_LF) begin
      flush_word();
    end else begin
      k = c;
      if (c >= uwe_pkg::CH_UA && c <= uwe_pkg::CH_UZ) k = c + uwe_pkg::CASE_GAP;
      if (((k >= uwe_pkg::CH_LA && k <= uwe_pkg::CH_LZ) || k == uwe_pkg::CH_APOS ||
           k == uwe_pkg::CH_HYPH) && cur_len < uwe_pkg::WORD_MAX) begin
        cur_word[cur_len] = k;
        cur_len++;
      end
    end
    if (eot) begin
      flush_word();
      title_pending = 1'b1;
      cur_len = 0;
      word_count = 0;
    end
    if (pending_beats.size() > before_n)
      pending_beats[pending_beats.size() - 1].last = 1'b1;
  endfunction

  task automatic send_byte(logic [7:0] c, logic eot = 1'b0);
    if (!quiet) begin
      while ($urandom_range(99) < 6) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_byte(c, eot);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_text(string s, logic eot_at_end = 1'b0);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], eot_at_end && (i == s.len() - 1));
  endtask

  // receiver: random stall, compare at rising edge
  always @(negedge clk) begin
    if (rst_n) out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 6);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      out_beat_t exp_b;
      emitted_beats++;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected transaction byte=%h status=%b last=%b",
                 $realtime, out_tdata, out_tuser[0], out_tlast);
        errors++;
      end else begin
        exp_b = pending_beats.pop_front();
        if (exp_b.ch !== out_tdata || exp_b.status !== out_tuser[0] ||
            exp_b.last !== out_tlast) begin
          $display("%0t: expected byte=%h st=%b last=%b, got byte=%h st=%b last=%b",
                   $realtime, exp_b.ch, exp_b.status, exp_b.last,
                   out_tdata, out_tuser[0], out_tlast);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_title_and_words();
    send_text("Title!\n");
    send_text("Hello\tworld\r\nHELLO don't x-ray ");
    send_text("a1b2c\x80\xff");
    send_byte(8'h00);
    send_text(" ;;; . z");
    send_text(" dup dup Dup", 1'b1);
    send_text("title ends on eot", 1'b1);
    wait_drained();
  endtask

  task automatic test_long_word();
    string w;
    logic [7:0] ch;
    w = "";
    for (int i = 0; i < 50; i++) begin
      ch = 8'(32'h41 + i % 26);
      w = {w, string'(ch)};
    end
    send_text("t\n");
    send_text({w, " ", w.substr(0, 48)}, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_text();
    for (int n = 0; n < 30; n++) begin
      int r;
      logic [7:0] c;
      r = $urandom_range(99);
      if (n > 5 && n < 25) quiet = 1'b1; else quiet = 1'b0;
      if (r < 50) c = uwe_pkg::CH_LA + 8'($urandom_range(3));
      else if (r < 60) c = uwe_pkg::CH_UA + 8'($urandom_range(3));
      else if (r < 80) c = ($urandom_range(1)) ? uwe_pkg::CH_SPACE : uwe_pkg::CH_LF;
      else if (r < 85) c = ($urandom_range(1)) ? uwe_pkg::CH_TAB : uwe_pkg::CH_CR;
      else if (r < 88) c = ($urandom_range(1)) ? uwe_pkg::CH_APOS : uwe_pkg::CH_HYPH;
      else c = 8'($urandom_range(255));
      send_byte(c, ($urandom_range(99) < 3) || n == 29);
    end
    quiet = 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    errors = 0;
    sent_bytes = 0;
    emitted_beats = 0;
    dropped_words = 0;
    quiet = 1'b0;
    title_pending = 1'b1;
    cur_len = 0;
    word_count = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_title_and_words();
    test_long_word();
    test_random_text();
    repeat (200) @(posedge clk);
    $display("sent %0d text bytes, checked %0d output transactions",
             sent_bytes, emitted_beats);
    $display("%0d words dropped on a full table", dropped_words);
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("unique_word_extractor test passed");
    end else begin
      $display("unique_word_extractor test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("unique_word_extractor test failed");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/uwe_pkg.sv
rtl/uwe_front.sv
rtl/uwe_queue.sv
rtl/uwe_back.sv
rtl/unique_word_extractor.sv
tb/tb_top.sv
